// ===== design/ffsa_pkg.sv =====
package ffsa_pkg;

    localparam int FREE_ENTRIES_DEF = 16;
    localparam int OFF_W            = 17;
    localparam int LEN_W            = 16;
    localparam int CFG_W            = 14;
    localparam int APB_AW           = 3;
    localparam int APB_DW           = 32;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE      = 2'd1,
        OP_FRAME_RST = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_SHIFT,
        S_INSERT
    } state_t;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } ext_t;

endpackage

// ===== design/ffsa_ram.sv =====
module ffsa_ram #(
    parameter int DEPTH = ffsa_pkg::FREE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  ffsa_pkg::ext_t           wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output ffsa_pkg::ext_t           rdata
);
    import ffsa_pkg::*;

    ext_t mem [DEPTH];
    ext_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffsa_cfg.sv =====
module ffsa_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffsa_pkg::APB_AW-1:0]  paddr,
    input  logic [ffsa_pkg::APB_DW-1:0]  pwdata,
    output logic [ffsa_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [ffsa_pkg::CFG_W-1:0]   frame_base
);
    import ffsa_pkg::*;

    logic [CFG_W-1:0] base_reg;
    logic [CFG_W-1:0] base_next;
    logic             hit;

    assign hit = (paddr[APB_AW-1:2] == '0);

    always_comb
    begin
        base_next = base_reg;
        if (psel && penable && pwrite && hit)
        begin
            base_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    assign prdata     = hit ? {{(APB_DW-CFG_W){1'b0}}, base_reg} : '0;
    assign pready     = 1'b1;
    assign frame_base = base_reg;

endmodule

// ===== design/ffsa_ctrl.sv =====
module ffsa_ctrl #(
    parameter int FREE_ENTRIES = ffsa_pkg::FREE_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic [ffsa_pkg::LEN_W-1:0]          slot_size,
    input  logic signed [ffsa_pkg::OFF_W-1:0]   slot_offset,
    input  logic [ffsa_pkg::CFG_W-1:0]          frame_base,
    output logic                                mem_we,
    output logic [$clog2(FREE_ENTRIES)-1:0]     mem_waddr,
    output ffsa_pkg::ext_t                      mem_wdata,
    output logic [$clog2(FREE_ENTRIES)-1:0]     mem_raddr,
    input  ffsa_pkg::ext_t                      mem_rdata,
    output logic                                done,
    output logic signed [ffsa_pkg::OFF_W-1:0]   granted_offset,
    output logic [1:0]                          status,
    output logic signed [ffsa_pkg::OFF_W-1:0]   low_water
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(FREE_ENTRIES);
    localparam int CW = $clog2(FREE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FREE_ENTRIES);

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [LEN_W-1:0]        size_reg, size_next;
    logic signed [OFF_W-1:0] off_reg, off_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [OFF_W-1:0] lw_reg, lw_next;
    logic [CW-1:0]           ptr_reg, ptr_next;
    logic                    pend_reg, pend_next;
    logic                    found_reg, found_next;
    logic [CW-1:0]           hit_idx_reg, hit_idx_next;
    ext_t                    ent_reg, ent_next;
    logic [IW-1:0]           src_reg, src_next;
    logic [IW-1:0]           dst_reg, dst_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic                    up_reg, up_next;
    logic                    done_reg, done_next;
    logic signed [OFF_W-1:0] granted_reg, granted_next;
    status_t                 status_reg, status_next;

    logic                    scan_hit;
    logic [OFF_W:0]          free_end;
    logic [LEN_W:0]          len_sum;
    logic                    can_merge;
    logic signed [OFF_W-1:0] lw_sub;

    assign scan_hit = (op_reg == OP_ALLOC) ? (mem_rdata.len >= size_reg)
                                           : ($signed(mem_rdata.off) > off_reg);
    assign free_end  = {off_reg[OFF_W-1], off_reg} + {2'b00, size_reg};
    assign len_sum   = {1'b0, ent_reg.len} + {1'b0, size_reg};
    assign can_merge = found_reg && (free_end == {ent_reg.off[OFF_W-1], ent_reg.off})
                       && !len_sum[LEN_W];
    assign lw_sub    = lw_reg - $signed({1'b0, size_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            lw_reg    <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lw_reg    <= lw_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        size_reg    <= size_next;
        off_reg     <= off_next;
        ptr_reg     <= ptr_next;
        found_reg   <= found_next;
        hit_idx_reg <= hit_idx_next;
        ent_reg     <= ent_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        rem_reg     <= rem_next;
        up_reg      <= up_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        size_next    = size_reg;
        off_next     = off_reg;
        count_next   = count_reg;
        lw_next      = lw_reg;
        ptr_next     = ptr_reg;
        pend_next    = pend_reg;
        found_next   = found_reg;
        hit_idx_next = hit_idx_reg;
        ent_next     = ent_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        rem_next     = rem_reg;
        up_next      = up_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        status_next  = status_reg;
        mem_we       = 1'b0;
        mem_waddr    = hit_idx_reg[IW-1:0];
        mem_wdata    = ent_reg;
        mem_raddr    = ptr_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = op_t'(opcode);
                    size_next    = slot_size;
                    off_next     = slot_offset;
                    granted_next = '0;
                    status_next  = ST_OK;
                    unique case (op_t'(opcode)) inside
                        OP_ALLOC, OP_FREE:
                        begin
                            if (slot_size == '0 || slot_size[1:0] != 2'b00)
                            begin
                                status_next = ST_BAD_SIZE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                pend_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_FRAME_RST:
                        begin
                            lw_next   = {{(OFF_W-CFG_W){frame_base[CFG_W-1]}}, frame_base};
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // one read issued per cycle, data checked in the next cycle
            S_SCAN:
            begin
                if (pend_reg && scan_hit)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = ptr_reg - 1'b1;
                    ent_next     = mem_rdata;
                    pend_next    = 1'b0;
                    state_next   = S_UPDATE;
                end
                else if (ptr_reg < count_reg)
                begin
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    found_next   = 1'b0;
                    hit_idx_next = count_reg;
                    pend_next    = 1'b0;
                    state_next   = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (found_reg)
                    begin
                        granted_next = $signed(ent_reg.off);
                        if (ent_reg.len == size_reg)
                        begin
                            src_next   = IW'(hit_idx_reg + 1'b1);
                            rem_next   = count_reg - 1'b1 - hit_idx_reg;
                            up_next    = 1'b0;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            mem_we        = 1'b1;
                            mem_wdata.off = ent_reg.off + {1'b0, size_reg};
                            mem_wdata.len = ent_reg.len - size_reg;
                            done_next     = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    else
                    begin
                        lw_next      = lw_sub;
                        granted_next = lw_sub;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (can_merge)
                begin
                    mem_we        = 1'b1;
                    mem_wdata.off = off_reg;
                    mem_wdata.len = len_sum[LEN_W-1:0];
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (count_reg == FULL_CNT)
                begin
                    status_next = ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    src_next   = IW'(count_reg - 1'b1);
                    rem_next   = count_reg - hit_idx_reg;
                    up_next    = 1'b1;
                    state_next = S_SHIFT;
                end
            end

            // move entries one place up or down, read ahead of write
            S_SHIFT:
            begin
                mem_raddr = src_reg;
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = mem_rdata;
                end
                if (rem_reg != '0)
                begin
                    pend_next = 1'b1;
                    dst_next  = up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    src_next  = up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (up_reg)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            S_INSERT:
            begin
                mem_we        = 1'b1;
                mem_wdata.off = off_reg;
                mem_wdata.len = size_reg;
                count_next    = count_reg + 1'b1;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign granted_offset = granted_reg;
    assign status         = status_reg;
    assign low_water      = lw_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("free table count beyond capacity");

    a_count_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg)
        else $error("table count changed outside item completion");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_SCAN) |-> !mem_we)
        else $error("table write during idle or scan");

    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done_reg)
        else $error("accepted item neither running nor completed");

endmodule

// ===== design/first_fit_stack_slot_allocator.sv =====
// First-fit stack slot allocator.
// Input channel: opcode, slot_size and slot_offset are taken at a rising
// edge where start is high and busy is low. One result per item: done is high
// for exactly one cycle with granted_offset, status and low_water; the
// receiver must take it in that cycle (no backpressure).
// Configuration: APB write to byte address 0 sets frame_base_offset (14-bit
// signed), restored into the mark by a frame-reset item. Write only when idle.
// Sequence: rejected items, frame resets and no-ops: done in the cycle after
// the start edge. Allocate/free: scan of the free-extent RAM at one entry per
// cycle, an update state, then for an exact-fit removal or an insert a shift
// of the tail at one entry per cycle through the single RAM write port, then
// the insert state for an insert, and done. The worst case is a free inserted
// at the head of a table one entry short of full. A new item may start in the
// done cycle.
// Reset: count of free extents zero, low-water mark zero, config zero.
// RAM contents are not cleared; only entries below the count are used.
module first_fit_stack_slot_allocator #(
    parameter int FREE_ENTRIES = ffsa_pkg::FREE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic [ffsa_pkg::LEN_W-1:0]         slot_size,
    input  logic signed [ffsa_pkg::OFF_W-1:0]  slot_offset,
    output logic                               done,
    output logic signed [ffsa_pkg::OFF_W-1:0]  granted_offset,
    output logic [1:0]                         status,
    output logic signed [ffsa_pkg::OFF_W-1:0]  low_water,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ffsa_pkg::APB_AW-1:0]        paddr,
    input  logic [ffsa_pkg::APB_DW-1:0]        pwdata,
    output logic [ffsa_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(FREE_ENTRIES);

    logic [CFG_W-1:0] frame_base;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [IW-1:0]    mem_raddr;
    ext_t             mem_wdata;
    ext_t             mem_rdata;

    ffsa_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .frame_base (frame_base)
    );

    ffsa_ram #(
        .DEPTH (FREE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffsa_ctrl #(
        .FREE_ENTRIES (FREE_ENTRIES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .slot_size      (slot_size),
        .slot_offset    (slot_offset),
        .frame_base     (frame_base),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .done           (done),
        .granted_offset (granted_offset),
        .status         (status),
        .low_water      (low_water)
    );

endmodule
